// ----- src/rdn_pkg.sv -----
// Shared types and fixed widths for the residual distribution normalizer.
// No dependencies; every other file of the block refers to this package.
package rdn_pkg;

  localparam int DATA_W       = 16;  // p, q and residual width
  localparam int SUM_W        = 22;  // running sum of up to 64 residuals
  localparam int OUT_W        = 17;  // Q1.x result width
  localparam int IN_TDATA_W   = 32;  // {q_value, p_value}
  localparam int OUT_TDATA_W  = 24;  // prob_value padded to whole bytes

  localparam logic [OUT_W-1:0] OUT_SAT = {OUT_W{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,   // take words, store residuals, accumulate the sum
    ST_READ,   // issue a buffer read for the current element
    ST_START,  // hand residual and sum to the divider
    ST_DIV,    // divider runs, one quotient bit per cycle
    ST_EMIT    // move the quotient into the output register
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// ----- src/rdn_buf.sv -----
// Residual buffer: one write port, one registered read port.
// Depends on rdn_pkg for the residual width.
module rdn_buf #(
  parameter int MAX_LEN = 64,
  parameter int AW      = 6
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [rdn_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [rdn_pkg::DATA_W-1:0] rd_data
);

  logic [rdn_pkg::DATA_W-1:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/rdn_div.sv -----
// Bit-serial restoring divider: (r << FRAC_BITS + d/2) / d, one quotient bit per cycle.
// Depends on rdn_pkg for widths and the status struct.
module rdn_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rdn_pkg::DATA_W-1:0]  residual,
  input  logic [rdn_pkg::SUM_W-1:0]   sum,
  output rdn_pkg::div_status_t        status,
  output logic [rdn_pkg::OUT_W-1:0]   quotient
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int NW    = rdn_pkg::DATA_W + FRAC_BITS + 1;
  localparam int CNT_W = $clog2(QW + 1);
  localparam int QX    = (QW > rdn_pkg::OUT_W) ? QW : rdn_pkg::OUT_W;

  logic [rdn_pkg::SUM_W-1:0] dvs;
  logic [rdn_pkg::SUM_W-1:0] rem;
  logic [QW-1:0]             shreg;  // numerator bits out, quotient bits in
  logic [CNT_W-1:0]          cnt;
  logic                      done;

  logic [rdn_pkg::SUM_W-1:0] dvs_next;
  logic [NW-1:0]             num;
  logic [rdn_pkg::SUM_W:0]   trial;
  logic [rdn_pkg::SUM_W:0]   diff;
  logic                      ge;
  logic [QX-1:0]             qx;

  // Zero sum divides by one LSB.
  assign dvs_next = (sum == '0) ? rdn_pkg::SUM_W'(1) : sum;
  assign num      = {1'b0, residual, FRAC_BITS'(0)} + NW'(dvs_next >> 1);

  assign trial = {rem, shreg[QW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_W'(QW);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - CNT_W'(1);
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // The quotient fits in QW bits, so the upper numerator bits are already below d.
  always_ff @(posedge clk) begin
    if (start) begin
      dvs   <= dvs_next;
      rem   <= rdn_pkg::SUM_W'(num[NW-1:QW]);
      shreg <= num[QW-1:0];
    end else if (cnt != '0) begin
      rem   <= ge ? diff[rdn_pkg::SUM_W-1:0] : trial[rdn_pkg::SUM_W-1:0];
      shreg <= {shreg[QW-2:0], ge};
    end
  end

  assign qx          = QX'(shreg);
  assign quotient    = ((qx >> rdn_pkg::OUT_W) != '0) ? rdn_pkg::OUT_SAT
                                                      : qx[rdn_pkg::OUT_W-1:0];
  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule

// ----- src/residual_distribution_normalizer.sv -----
// Top level of the residual distribution normalizer.
// Depends on rdn_pkg, rdn_buf and rdn_div.
//
// Usage:
//   Slave stream (s_*) carries one element per word: p and q as unsigned
//   Q0.16 fractions, s_tlast on the final element of a distribution.
//   Each word stores max(0, p - q) and adds it to a running sum. The word
//   with s_tlast, or the word that fills MAX_LEN entries, closes the run.
//   Master stream (m_*) then returns one word per stored element, each the
//   residual divided by the sum in unsigned Q1.FRAC_BITS, rounded to
//   nearest, m_tlast on the final element. A zero sum gives all zeros.
// Timing:
//   Loading takes one word per cycle. After the closing word, s_tready is
//   low and each result passes in turn through buffer read, divider load,
//   FRAC_BITS + 1 steps of the bit-serial divider, its done flag and the
//   move to the output register; the next element starts only after that.
//   The divider sets the rate, and receiver stalls hold the emit step.
//   Loading of the next run starts once the last result is in the output
//   register.
// Reset and stall:
//   rst clears the sum, the element count and the output valid. When the
//   receiver holds m_tready low, the output register holds its word and
//   the sequencer waits in its emit step; no result is dropped.
module residual_distribution_normalizer #(
  parameter int MAX_LEN   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rdn_pkg::IN_TDATA_W-1:0]   s_tdata,   // [15:0] p_value, [31:16] q_value
  input  logic                             s_tlast,   // last_item
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rdn_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [16:0] prob_value, [23:17] zero
  output logic                             m_tlast    // run_end
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  rdn_pkg::state_t state, state_next;

  logic [AW-1:0]                count, count_next;   // write index of the run
  logic [AW-1:0]                idx, idx_next;       // element being normalized
  logic [rdn_pkg::SUM_W-1:0]    sum, sum_next;
  logic [rdn_pkg::OUT_W-1:0]    out_data, out_data_next;
  logic                         out_last, out_last_next;
  logic                         out_valid, out_valid_next;

  logic [rdn_pkg::DATA_W-1:0]   p_value, q_value, residual;
  logic                         accept, run_close;
  logic                         wr_en, rd_en, div_start;
  logic [rdn_pkg::DATA_W-1:0]   rd_data;
  rdn_pkg::div_status_t         div_status;
  logic [rdn_pkg::OUT_W-1:0]    quotient;
  logic                         out_free;

  assign p_value  = s_tdata[rdn_pkg::DATA_W-1:0];
  assign q_value  = s_tdata[2*rdn_pkg::DATA_W-1:rdn_pkg::DATA_W];
  assign residual = (p_value > q_value) ? (p_value - q_value) : '0;

  assign s_tready  = (state == rdn_pkg::ST_LOAD);
  assign accept    = s_tvalid && s_tready;
  assign run_close = s_tlast || (count == AW'(MAX_LEN - 1));
  assign out_free  = !out_valid || m_tready;

  rdn_buf #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count),
    .wr_data (residual),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  rdn_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .residual (rd_data),
    .sum      (sum),
    .status   (div_status),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rdn_pkg::ST_LOAD;
      count     <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      sum       <= sum_next;
      out_valid <= out_valid_next;
    end
  end

  // Payload and index need no reset.
  always_ff @(posedge clk) begin
    idx      <= idx_next;
    out_data <= out_data_next;
    out_last <= out_last_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    sum_next       = sum;
    out_data_next  = out_data;
    out_last_next  = out_last;
    out_valid_next = out_valid && !m_tready;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    div_start      = 1'b0;
    unique case (state)
      rdn_pkg::ST_LOAD: begin
        if (accept) begin
          wr_en    = 1'b1;
          sum_next = sum + rdn_pkg::SUM_W'(residual);
          if (run_close) begin
            // hold count at the final index; it marks the end of the run
            idx_next   = '0;
            state_next = rdn_pkg::ST_READ;
          end else begin
            count_next = count + AW'(1);
          end
        end
      end
      rdn_pkg::ST_READ: begin
        rd_en      = 1'b1;
        state_next = rdn_pkg::ST_START;
      end
      rdn_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = rdn_pkg::ST_DIV;
      end
      rdn_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_next = rdn_pkg::ST_EMIT;
        end
      end
      rdn_pkg::ST_EMIT: begin
        if (out_free) begin
          out_data_next  = quotient;
          out_last_next  = (idx == count);
          out_valid_next = 1'b1;
          if (idx == count) begin
            // run done: clear for the next distribution
            count_next = '0;
            sum_next   = '0;
            state_next = rdn_pkg::ST_LOAD;
          end else begin
            idx_next   = idx + AW'(1);
            state_next = rdn_pkg::ST_READ;
          end
        end
      end
      default: begin
        state_next = rdn_pkg::ST_LOAD;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = rdn_pkg::OUT_TDATA_W'(out_data);
  assign m_tlast  = out_last;

endmodule

// ----- src/rdn_check.sv -----
// Port-level checker for the residual distribution normalizer, with its bind.
// Depends on rdn_pkg for port widths.
module rdn_check #(
  parameter int FRAC_BITS = 16
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [rdn_pkg::IN_TDATA_W-1:0]   s_tdata,
  input logic                             s_tlast,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [rdn_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                             m_tlast
);

  localparam logic [rdn_pkg::OUT_W-1:0] OUT_LIMIT =
    (FRAC_BITS <= 16) ? rdn_pkg::OUT_W'(1 << FRAC_BITS) : rdn_pkg::OUT_SAT;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  a_prob_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[rdn_pkg::OUT_W-1:0] <= OUT_LIMIT
                 && m_tdata[rdn_pkg::OUT_TDATA_W-1:rdn_pkg::OUT_W] == '0)
    else $error("normalized value out of range");

  a_close_run: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready)
    else $error("input still taken after the closing word");

endmodule

bind residual_distribution_normalizer rdn_check #(.FRAC_BITS(FRAC_BITS)) u_rdn_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- tb/rdn_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the residual distribution normalizer: watches both streams,
// predicts the normalized words of each closed run and compares them. Uses rdn_pkg.
module rdn_result_checker #(
  parameter int MAX_LEN   = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [rdn_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [rdn_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            m_tlast,
  output int                              mismatches,
  output int                              pending,
  output int                              checked
);

  localparam int RUN_CAP = (MAX_LEN > 64) ? 64 : ((MAX_LEN < 1) ? 1 : MAX_LEN);

  typedef struct packed {
    logic [rdn_pkg::OUT_W-1:0] prob;
    logic                      run_end;
  } norm_word_t;

  logic [rdn_pkg::DATA_W-1:0] residual_mem [RUN_CAP];
  logic [rdn_pkg::SUM_W-1:0]  run_sum;
  logic [6:0]                 run_len;
  norm_word_t                 norm_expected [$];

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  // Residual over the run total as Q1.FRAC_BITS, round half up, clamp to 17 bits.
  function automatic logic [rdn_pkg::OUT_W-1:0] scale_residual(
      input logic [rdn_pkg::DATA_W-1:0] resid,
      input logic [rdn_pkg::SUM_W-1:0]  total);
    logic [63:0] divisor;
    logic [63:0] quot;
    divisor = (total == '0) ? 64'd1 : 64'(total);
    quot    = ((64'(resid) << FRAC_BITS) + (divisor >> 1)) / divisor;
    return (quot > 64'(rdn_pkg::OUT_SAT)) ? rdn_pkg::OUT_SAT : quot[rdn_pkg::OUT_W-1:0];
  endfunction

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("[%0t] %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin : track
    logic [rdn_pkg::DATA_W-1:0] p_in;
    logic [rdn_pkg::DATA_W-1:0] q_in;
    logic [rdn_pkg::DATA_W-1:0] resid;
    norm_word_t                 head;
    int                         k;
    if (rst) begin
      run_sum = '0;
      run_len = '0;
      norm_expected.delete();
    end else begin
      // results first: a word accepted at this edge cannot have produced one yet
      if (m_tvalid && m_tready) begin
        if (norm_expected.size() == 0) begin
          report("result word with nothing expected", 32'd0, 32'(m_tdata));
        end else begin
          head = norm_expected.pop_front();
          if (m_tdata[rdn_pkg::OUT_W-1:0] !== head.prob)
            report("prob_value", 32'(head.prob), 32'(m_tdata[rdn_pkg::OUT_W-1:0]));
          if (m_tlast !== head.run_end)
            report("run_end", 32'(head.run_end), 32'(m_tlast));
          if (m_tdata[rdn_pkg::OUT_TDATA_W-1:rdn_pkg::OUT_W] !== '0)
            report("tdata padding", 32'd0,
                   32'(m_tdata[rdn_pkg::OUT_TDATA_W-1:rdn_pkg::OUT_W]));
        end
        checked++;
      end
      if (s_tvalid && s_tready) begin
        p_in  = s_tdata[rdn_pkg::DATA_W-1:0];
        q_in  = s_tdata[2*rdn_pkg::DATA_W-1:rdn_pkg::DATA_W];
        resid = (p_in > q_in) ? p_in - q_in : '0;
        residual_mem[run_len % RUN_CAP] = resid;
        run_sum = run_sum + rdn_pkg::SUM_W'(resid);
        run_len = run_len + 7'd1;
        // close the run on tlast or when the buffer fills
        if (s_tlast || run_len >= RUN_CAP) begin
          for (k = 0; k < int'(run_len); k++)
            norm_expected.push_back('{prob:    scale_residual(residual_mem[k], run_sum),
                                      run_end: (k == int'(run_len) - 1)});
          run_sum = '0;
          run_len = '0;
        end
      end
    end
    pending <= norm_expected.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top of the residual distribution normalizer testbench: clock, reset, stimulus
// and verdict. Depends on rdn_pkg, the block and rdn_result_checker.
module tb;

  localparam int MAX_LEN     = 64;
  localparam int FRAC_BITS   = 16;
  localparam int WORD_CYCLES = FRAC_BITS + 5;  // block's cost per result word
  localparam int RANDOM_WORDS = 193;           // directed runs add 17 more
  localparam int QUIET_LIMIT = 3000;           // cycles with no word moving on either side

  typedef enum int {
    MIX_UNIFORM,   // p and q independent, about half the residuals clip to zero
    MIX_DOMINANT,  // q at or below p, large residuals
    MIX_EQUAL,     // p == q, zero residual
    MIX_EXTREME,   // corner values only
    MIX_SMALL,     // many small probabilities, as in a real distribution
    MIX_ANY        // pick one of the above per word
  } pair_mix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  logic [rdn_pkg::IN_TDATA_W-1:0]    s_tdata  = '0;  // [15:0] p_value, [31:16] q_value
  logic                              s_tlast  = 1'b0;  // last_item
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  logic [rdn_pkg::OUT_TDATA_W-1:0]   m_tdata;  // [16:0] prob_value, [23:17] zero
  logic                              m_tlast;  // run_end

  int mismatches;
  int pending;
  int checked;

  int words_sent  = 0;
  int runs_sent   = 0;
  int full_runs   = 0;
  int quiet_count = 0;
  bit steady      = 1'b0;  // set to run without any gaps or stalls

  always #5 clk = ~clk;

  residual_distribution_normalizer #(
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  rdn_result_checker #(
    .MAX_LEN   (MAX_LEN),
    .FRAC_BITS (FRAC_BITS)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // Mostly short gaps, now and then a long one; none in steady stretches.
  function automatic int pick_gap(input int longest);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, longest);
  endfunction

  // Receiver: open for a while, then maybe stall. Any edge can land mid-divide
  // or right on the emit step.
  initial begin : drain
    int open_len;
    int stall_len;
    @(posedge clk);
    forever begin
      open_len = $urandom_range(1, 24);
      m_tready <= 1'b1;
      repeat (open_len) @(posedge clk);
      stall_len = pick_gap(40);
      if (stall_len > 0) begin
        m_tready <= 1'b0;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_count <= 0;
    else
      quiet_count <= quiet_count + 1;
    if (quiet_count == QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, pending);
      $display("residual_distribution_normalizer: mismatch");
      $finish;
    end
  end

  // Present one word and hold it until the block takes it.
  task automatic send_pair(input logic [15:0] p, input logic [15:0] q, input logic last);
    s_tdata  <= {q, p};
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Drop valid for the requested number of cycles; put junk on the data lines meanwhile.
  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      s_tdata  <= $urandom;
      s_tlast  <= 1'($urandom_range(0, 1));
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result word has come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic make_pair(input pair_mix_t mix, output logic [15:0] p, output logic [15:0] q);
    pair_mix_t m;
    logic [15:0] corner [4];
    corner = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
    m = (mix == MIX_ANY) ? pair_mix_t'($urandom_range(0, 4)) : mix;
    case (m)
      MIX_DOMINANT: begin
        p = 16'($urandom_range(0, 65535));
        q = 16'($urandom_range(0, p));
      end
      MIX_EQUAL: begin
        p = 16'($urandom);
        q = p;
      end
      MIX_EXTREME: begin
        p = corner[$urandom_range(0, 3)];
        q = corner[$urandom_range(0, 3)];
      end
      MIX_SMALL: begin
        p = 16'($urandom_range(0, 2047));
        q = 16'($urandom_range(0, 2047));
      end
      default: begin
        p = 16'($urandom);
        q = 16'($urandom);
      end
    endcase
  endtask

  // One run of len words; tlast on the final word only when close_with_last.
  task automatic send_run(input int len, input pair_mix_t mix, input bit close_with_last);
    logic [15:0] p;
    logic [15:0] q;
    for (int i = 0; i < len; i++) begin
      make_pair(mix, p, q);
      send_pair(p, q, close_with_last && (i == len - 1));
      idle_sender(pick_gap(30));
    end
    runs_sent++;
    if (len == MAX_LEN) full_runs++;
  endtask

  initial begin : stimulus
    int start_words;
    int run_idx;
    int len;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed runs: single full-scale residual, zero-sum single, thirds (rounding),
    // mixed with zeros, all-zero run, mixed with clipping, and alternating bits.
    send_pair(16'hFFFF, 16'h0000, 1'b1);                runs_sent++;
    send_pair(16'h0000, 16'hFFFF, 1'b1);                runs_sent++;
    send_pair(16'h0001, 16'h0000, 1'b0);
    send_pair(16'h0002, 16'h0000, 1'b1);                runs_sent++;
    send_pair(16'hFFFF, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'hFFFF, 16'hFFFE, 1'b1);                runs_sent++;
    send_pair(16'h0000, 16'h0000, 1'b0);
    send_pair(16'hFFFF, 16'hFFFF, 1'b0);
    send_pair(16'd100,  16'd200,  1'b1);                runs_sent++;
    send_pair(16'd40000, 16'd7,   1'b0);
    send_pair(16'd12345, 16'd54321, 1'b0);
    send_pair(16'h0001, 16'h0000, 1'b1);                runs_sent++;
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b0);
    send_pair(16'hFFFF, 16'h8000, 1'b1);                runs_sent++;
    wait_drained();

    // Random runs: mostly short, two that fill the buffer (one closed by the
    // fill alone, one with tlast on the 64th word), one gap-free stretch.
    start_words = words_sent;
    run_idx = 0;
    while (words_sent - start_words < RANDOM_WORDS) begin
      steady = (run_idx >= 5 && run_idx <= 8);
      if (run_idx == 3) begin
        send_run(MAX_LEN, MIX_ANY, 1'b0);
      end else if (run_idx == 10) begin
        send_run(MAX_LEN, MIX_DOMINANT, 1'b1);
      end else begin
        len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 24);
        send_run(len, pair_mix_t'($urandom_range(0, 5)), 1'b1);
      end
      if (!steady && $urandom_range(0, 3) == 0) wait_drained();
      run_idx++;
    end
    steady = 1'b0;

    // Drain, then give any stray word time to show up.
    wait_drained();
    repeat (3 * WORD_CYCLES) @(posedge clk);

    $display("covered %0d words in %0d runs, %0d of them filling the buffer",
             words_sent, runs_sent, full_runs);
    $display("checked %0d result words, %0d mismatches, %0d still outstanding",
             checked, mismatches, pending);
    if (mismatches == 0 && pending == 0)
      $display("residual_distribution_normalizer: match");
    else
      $display("residual_distribution_normalizer: mismatch");
    $finish;
  end

endmodule
